// ===== hw/rtl/vne_pkg.sv =====
`default_nettype none
package vne_pkg;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned NORM_W  = 8;
	localparam int unsigned THICK_W = 16;
	localparam int unsigned Q_W     = 8;
	localparam int unsigned S_W     = 16;
	localparam int unsigned A_W     = 23;
	localparam int unsigned R_W     = 30;
	localparam int unsigned QS_W    = 24;
	localparam int unsigned Q2S_W   = 33;
	localparam int unsigned STEPS   = 8;
	localparam logic [THICK_W-1:0] THICK_RESET = 16'd256;

	// Running state of the bitwise root/divide search for one axis.
	typedef struct packed {
		logic [Q_W-1:0]   q;
		logic [QS_W-1:0]  qs;
		logic [Q2S_W-1:0] q2s;
		logic [R_W-1:0]   r;
	} axis_t;
endpackage
`default_nettype wire

// ===== hw/rtl/vne_qstep.sv =====
`default_nettype none
module vne_qstep (
	input  wire vne_pkg::axis_t       a,
	input  wire [vne_pkg::S_W-1:0]    s,
	input  wire [2:0]                 sh,
	output vne_pkg::axis_t            y
);
	localparam int unsigned Q2S_W_L = vne_pkg::Q2S_W + 1;
	logic [Q2S_W_L-1:0] c2s;
	logic [Q2S_W_L-1:0] t_qs;
	logic [Q2S_W_L-1:0] t_s;

	// (q + b)^2 s = q^2 s + 2 b q s + b^2 s, with b = 2^sh
	always_comb begin
		t_qs = Q2S_W_L'(a.qs) << ({2'b0, sh} + 4'd1);
		t_s  = Q2S_W_L'(s) << {sh, 1'b0};
		c2s  = Q2S_W_L'(a.q2s) + t_qs + t_s;
		y    = a;
		if (c2s <= Q2S_W_L'(a.r)) begin
			y.q   = a.q | (vne_pkg::Q_W'(1) << sh);
			y.qs  = a.qs + (vne_pkg::QS_W'(s) << sh);
			y.q2s = c2s[vne_pkg::Q2S_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/vertex_normal_extrusion.sv =====
`default_nettype none
// Vertex normal extrusion: pushes each vertex outward along its unit normal
// by the thickness register (unsigned Q8.8), for outline hull baking.
// Input channel: in_valid / in_stall with pos_x..z (16 bit signed) and
// norm_x..z (8 bit signed). A word is taken when in_valid is high and
// in_stall is low. Output channel: out_valid / out_stall with out_x..z and
// moved; the receiver drives out_stall.
// Eleven register stages: one for the squares and the |n_i|*thickness
// products, one for squaring those, eight stages of the bitwise root/divide
// search (one quotient bit each), one for the add. The first stage loads on
// the accepting edge. Throughput is one word per cycle unless stalled.
// When the receiver stalls a valid output, the whole pipe holds and in_stall
// rises in the same cycle.
// Reset clears all valid bits and loads thickness with 1.0 (256).
// A zero normal passes the position through with moved low.
// Write thickness only while the pipe is empty.
module vertex_normal_extrusion (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         thickness_we,
	input  wire  [15:0] thickness_wdata,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  signed [15:0] pos_x,
	input  wire  signed [15:0] pos_y,
	input  wire  signed [15:0] pos_z,
	input  wire  signed [7:0]  norm_x,
	input  wire  signed [7:0]  norm_y,
	input  wire  signed [7:0]  norm_z,
	output logic        out_valid,
	input  wire         out_stall,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	output logic        moved
);
	localparam int unsigned NS = vne_pkg::STEPS;

	logic [15:0] thick_q;
	logic        en;

	// stage 1
	logic                      v_s1;
	logic [2:0][15:0]          pos_s1;
	logic [2:0]                neg_s1;
	logic [vne_pkg::S_W-1:0]   s_s1;
	logic [2:0][vne_pkg::A_W-1:0] a_s1;

	// stage 2 and search stages: index 0 is stage 2, index k is stage 2+k
	logic                    v_s   [0:NS];
	logic [2:0][15:0]        pos_s [0:NS];
	logic [2:0]              neg_s [0:NS];
	logic [vne_pkg::S_W-1:0] s_s   [0:NS];
	vne_pkg::axis_t          ax_s  [0:NS][3];
	vne_pkg::axis_t          ax_nx [1:NS][3];

	logic signed [7:0] nin [3];
	logic [7:0]        nabs [3];
	logic [2:0][15:0]  pin;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= vne_pkg::THICK_RESET;
		end else if (thickness_we) begin
			thick_q <= thickness_wdata;
		end
	end

	always_comb begin
		nin[0] = norm_x;
		nin[1] = norm_y;
		nin[2] = norm_z;
		pin    = {pos_z, pos_y, pos_x};
		for (int i = 0; i < 3; i++) begin
			nabs[i] = nin[i][7] ? 8'(-nin[i]) : 8'(nin[i]);
		end
	end

	// Stage 1: squared norm and |n_i| * thickness.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pin;
			s_s1   <= vne_pkg::S_W'(16'(nabs[0] * nabs[0]) + 16'(nabs[1] * nabs[1])
				+ 16'(nabs[2] * nabs[2]));
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= nin[i][7];
				a_s1[i]   <= vne_pkg::A_W'(nabs[i] * thick_q);
			end
		end
	end

	// Stage 2: square the products, drop the 2^16 scale, clear the search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [2*vne_pkg::A_W-1:0] sq;
		if (en) begin
			pos_s[0] <= pos_s1;
			neg_s[0] <= neg_s1;
			s_s[0]   <= s_s1;
			for (int i = 0; i < 3; i++) begin
				sq = a_s1[i] * a_s1[i];
				ax_s[0][i].q   <= '0;
				ax_s[0][i].qs  <= '0;
				ax_s[0][i].q2s <= '0;
				ax_s[0][i].r   <= sq[16 +: vne_pkg::R_W];
			end
		end
	end

	// Search stages: settle one quotient bit per stage, MSB first.
	for (genvar k = 1; k <= NS; k++) begin : g_step
		for (genvar i = 0; i < 3; i++) begin : g_axis
			vne_qstep u_step (
				.a  (ax_s[k-1][i]),
				.s  (s_s[k-1]),
				.sh (3'(NS - k)),
				.y  (ax_nx[k][i])
			);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pos_s[k] <= pos_s[k-1];
				neg_s[k] <= neg_s[k-1];
				s_s[k]   <= s_s[k-1];
				for (int i = 0; i < 3; i++) begin
					ax_s[k][i] <= ax_nx[k][i];
				end
			end
		end
	end

	// Output stage: apply sign, add with wrap; a zero normal adds nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		logic [15:0] off [3];
		logic        nz;
		if (en) begin
			nz = (s_s[NS] != '0);
			for (int i = 0; i < 3; i++) begin
				off[i] = nz ? {8'b0, ax_s[NS][i].q} : 16'd0;
				if (neg_s[NS][i]) begin
					off[i] = 16'(-off[i]);
				end
			end
			out_x <= pos_s[NS][0] + off[0];
			out_y <= pos_s[NS][1] + off[1];
			out_z <= pos_s[NS][2] + off[2];
			moved <= nz;
		end
	end

	a_stall_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("in_stall does not follow the output stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted word did not enter stage 1");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s[NS]) && $stable(v_s1))
		else $error("pipe moved while stalled");
endmodule
`default_nettype wire
